/* sv/swfr_pkg.sv */
// Shared types and constants for the stop-and-wait frame receiver.
// Used by the frame checker, the result sequencer, the top level and the testbench.
// Depends on nothing else.
`default_nettype none

package swfr_pkg;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] PAD_CHAR   = 8'h7E;

  // Byte counter: the last byte of a full frame arrives at count 7; 8 or 9 is overlong.
  localparam logic [3:0] COUNT_LAST = 4'd7;
  localparam logic [3:0] COUNT_OVER = 4'd9;

  localparam int unsigned FRAME_LEN = 8;

  // Configuration register indexes.
  localparam logic [1:0] REG_OWN_ADDRESS   = 2'd0;
  localparam logic [1:0] REG_PEER_ADDRESS  = 2'd1;
  localparam logic [1:0] REG_START_FLAG    = 2'd2;
  localparam logic [1:0] REG_STRIP_PADDING = 2'd3;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_EOM     = 2'd2
  } kind_e;

  // Result slots walked by the sequencer for one accepted frame.
  typedef enum logic [3:0] {
    SLOT_PAY0  = 4'd0,
    SLOT_PAY1  = 4'd1,
    SLOT_START = 4'd2,
    SLOT_PEER  = 4'd3,
    SLOT_OWN   = 4'd4,
    SLOT_SEQ   = 4'd5,
    SLOT_PAR   = 4'd6,
    SLOT_ZERO  = 4'd7,
    SLOT_EOM   = 4'd8
  } slot_e;

  typedef struct packed {
    logic [7:0] own_address;
    logic [7:0] peer_address;
    logic [7:0] start_flag;
    logic       strip_padding;
  } cfg_t;

  // Everything the sequencer needs to replay the results of one accepted frame.
  typedef struct packed {
    logic       keep0;
    logic       keep1;
    logic [7:0] pay0;
    logic [7:0] pay1;
    logic       seq;
    logic       eom;
  } job_t;

  // Handoff between the frame checker and the sequencer.
  typedef struct packed {
    logic push;
    job_t job;
  } job_req_t;

endpackage

`default_nettype wire

/* sv/swfr_if.sv */
// Valid/ready channel interfaces of the stop-and-wait frame receiver:
// received bytes, result bytes and configuration writes.
// Depends on nothing else.
`default_nettype none

interface swfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface swfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_kind, output out_byte, output out_last,
                  input ready);
  modport sink (input valid, input out_kind, input out_byte, input out_last,
                output ready);
endinterface

interface swfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/swfr_frame.sv */
// Frame checker: input register, frame buffer, byte counter and sequence bit.
// Judges a frame on its end mark and hands accepted frames to the sequencer.
// Depends on swfr_pkg and swfr_if.
`default_nettype none

module swfr_frame (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  swfr_in_if.sink                in_i,
  input  wire swfr_pkg::cfg_t    cfg_i,
  input  wire logic              job_room_i,
  output swfr_pkg::job_req_t     job_req_o
);

  logic       in_valid_q;
  logic [7:0] rx_q;
  logic       end_q;

  logic [3:0] count_q, count_d;
  logic       seq_q, seq_d;
  logic [7:0] store_q [swfr_pkg::FRAME_LEN];

  logic consume;
  logic parity;
  logic frame_ok;
  logic last_zero;

  // A byte without an end mark never causes results, so it moves on even
  // while the sequencer is still busy with the previous frame.
  assign consume  = in_valid_q && (!end_q || job_room_i);
  assign in_i.ready = !in_valid_q || consume;

  assign parity = store_q[0][0] ^ store_q[1][0] ^ store_q[2][0]
                ^ store_q[3][0] ^ store_q[4][0] ^ store_q[5][0];

  // The byte in the input register is frame byte 7 when the count stands at 7.
  assign frame_ok = end_q && (count_q == swfr_pkg::COUNT_LAST)
                 && (store_q[1] == cfg_i.own_address)
                 && (store_q[3] == {swfr_pkg::ASCII_ZERO[7:1], seq_q})
                 && (store_q[6] == {swfr_pkg::ASCII_ZERO[7:1], parity});

  assign last_zero = (rx_q == swfr_pkg::ASCII_ZERO);

  always_comb begin
    job_req_o.push      = consume && frame_ok;
    job_req_o.job.keep0 = !(cfg_i.strip_padding && (store_q[4] == swfr_pkg::PAD_CHAR));
    job_req_o.job.keep1 = !(cfg_i.strip_padding && (store_q[5] == swfr_pkg::PAD_CHAR));
    job_req_o.job.pay0  = store_q[4];
    job_req_o.job.pay1  = store_q[5];
    job_req_o.job.seq   = !seq_q;
    job_req_o.job.eom   = last_zero;
  end

  always_comb begin
    count_d = count_q;
    seq_d   = seq_q;
    if (consume) begin
      if (end_q) begin
        count_d = 4'd0;
      end else if (count_q < swfr_pkg::COUNT_OVER) begin
        count_d = count_q + 4'd1;
      end
    end
    if (job_req_o.push) begin
      seq_d = last_zero ? 1'b0 : !seq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      count_q    <= 4'd0;
      seq_q      <= 1'b0;
    end else begin
      count_q <= count_d;
      seq_q   <= seq_d;
      if (in_i.valid && in_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      rx_q  <= in_i.rx_byte;
      end_q <= in_i.frame_end;
    end
    if (consume && !count_q[3]) begin
      store_q[count_q[2:0]] <= rx_q;
    end
  end

endmodule

`default_nettype wire

/* sv/swfr_emit.sv */
// Result sequencer: holds one accepted frame and walks its payload, ack and
// end-of-message results into the output register, one per unstalled cycle.
// Depends on swfr_pkg and swfr_if.
`default_nettype none

module swfr_emit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire swfr_pkg::cfg_t    cfg_i,
  input  wire swfr_pkg::job_req_t job_req_i,
  output logic                   job_room_o,
  swfr_out_if.source             out_o
);

  logic              job_valid_q;
  swfr_pkg::job_t    job_q;
  swfr_pkg::slot_e   slot_q, slot_d;

  logic              out_valid_q;
  swfr_pkg::kind_e   out_kind_q;
  logic [7:0]        out_byte_q;
  logic              out_last_q;

  logic              adv;
  logic              done;
  swfr_pkg::kind_e   kind;
  logic [7:0]        res_byte;
  swfr_pkg::slot_e   slot_next;
  swfr_pkg::slot_e   slot_first;
  logic              ack_par;

  assign adv        = job_valid_q && (!out_valid_q || out_o.ready);
  assign job_room_o = !job_valid_q || (adv && done);

  assign ack_par = cfg_i.start_flag[0] ^ cfg_i.peer_address[0]
                 ^ cfg_i.own_address[0] ^ job_q.seq;

  // Dropped payload bytes are skipped; the walk never stops on their slots.
  always_comb begin
    if (job_req_i.job.keep0) begin
      slot_first = swfr_pkg::SLOT_PAY0;
    end else if (job_req_i.job.keep1) begin
      slot_first = swfr_pkg::SLOT_PAY1;
    end else begin
      slot_first = swfr_pkg::SLOT_START;
    end
  end

  always_comb begin
    kind      = swfr_pkg::KIND_ACK;
    res_byte  = swfr_pkg::ASCII_ZERO;
    slot_next = slot_q;
    done      = 1'b0;
    unique case (slot_q)
      swfr_pkg::SLOT_PAY0: begin
        kind      = swfr_pkg::KIND_PAYLOAD;
        res_byte  = job_q.pay0;
        slot_next = job_q.keep1 ? swfr_pkg::SLOT_PAY1 : swfr_pkg::SLOT_START;
      end
      swfr_pkg::SLOT_PAY1: begin
        kind      = swfr_pkg::KIND_PAYLOAD;
        res_byte  = job_q.pay1;
        slot_next = swfr_pkg::SLOT_START;
      end
      swfr_pkg::SLOT_START: begin
        res_byte  = cfg_i.start_flag;
        slot_next = swfr_pkg::SLOT_PEER;
      end
      swfr_pkg::SLOT_PEER: begin
        res_byte  = cfg_i.peer_address;
        slot_next = swfr_pkg::SLOT_OWN;
      end
      swfr_pkg::SLOT_OWN: begin
        res_byte  = cfg_i.own_address;
        slot_next = swfr_pkg::SLOT_SEQ;
      end
      swfr_pkg::SLOT_SEQ: begin
        res_byte  = {swfr_pkg::ASCII_ZERO[7:1], job_q.seq};
        slot_next = swfr_pkg::SLOT_PAR;
      end
      swfr_pkg::SLOT_PAR: begin
        res_byte  = {swfr_pkg::ASCII_ZERO[7:1], ack_par};
        slot_next = swfr_pkg::SLOT_ZERO;
      end
      swfr_pkg::SLOT_ZERO: begin
        res_byte  = swfr_pkg::ASCII_ZERO;
        slot_next = swfr_pkg::SLOT_EOM;
        done      = !job_q.eom;
      end
      swfr_pkg::SLOT_EOM: begin
        kind     = swfr_pkg::KIND_EOM;
        res_byte = 8'd0;
        done     = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      slot_q      <= swfr_pkg::SLOT_START;
      out_valid_q <= 1'b0;
    end else begin
      slot_q <= slot_d;
      if (job_req_i.push) begin
        job_valid_q <= 1'b1;
      end else if (adv && done) begin
        job_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    slot_d = slot_q;
    if (job_req_i.push) begin
      slot_d = slot_first;
    end else if (adv) begin
      slot_d = slot_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_req_i.push) begin
      job_q <= job_req_i.job;
    end
    if (adv) begin
      out_kind_q <= kind;
      out_byte_q <= res_byte;
      out_last_q <= done;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_kind = out_kind_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.out_last = out_last_q;

endmodule

`default_nettype wire

/* sv/stop_wait_frame_receiver_top.sv */
// Receiving side of a stop-and-wait link: bytes enter one per request and are
// buffered per frame; an accepted 8-byte frame yields its payload bytes, a
// 6-byte ack frame and, when the frame closes the message, an end marker.
// A byte is taken every cycle unless an end-marked byte waits in the input
// register, and it passes through that register to the frame checker. The
// end-marked byte of an accepted frame starts a burst of six to nine results
// that the result sequencer sends one per cycle unless the output stalls.
// Bytes without an end mark keep flowing during a burst; the next end-marked
// byte waits in the input register until the burst's last result has been
// loaded into the output register. Configuration writes take effect at once
// and must only be issued while no frame results are pending.
// Depends on swfr_pkg, swfr_if, swfr_frame and swfr_emit.
`default_nettype none

module stop_wait_frame_receiver_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  swfr_in_if.sink    in_i,
  swfr_out_if.source out_o,
  swfr_cfg_if.sink   cfg_i
);

  logic [7:0] own_address_q;
  logic [7:0] peer_address_q;
  logic [7:0] start_flag_q;
  logic       strip_padding_q;

  swfr_pkg::cfg_t     cfg;
  swfr_pkg::job_req_t job_req;
  logic               job_room;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q   <= 8'd66;
      peer_address_q  <= 8'd65;
      start_flag_q    <= 8'd111;
      strip_padding_q <= 1'b1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        swfr_pkg::REG_OWN_ADDRESS:   own_address_q   <= cfg_i.data;
        swfr_pkg::REG_PEER_ADDRESS:  peer_address_q  <= cfg_i.data;
        swfr_pkg::REG_START_FLAG:    start_flag_q    <= cfg_i.data;
        swfr_pkg::REG_STRIP_PADDING: strip_padding_q <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.own_address   = own_address_q;
    cfg.peer_address  = peer_address_q;
    cfg.start_flag    = start_flag_q;
    cfg.strip_padding = strip_padding_q;
  end

  swfr_frame u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_i      (cfg),
    .job_room_i (job_room),
    .job_req_o  (job_req)
  );

  swfr_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .job_req_i  (job_req),
    .job_room_o (job_room),
    .out_o      (out_o)
  );

  // A new frame must never overwrite one whose results are still being sent.
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_req.push |-> job_room)
    else $error("frame handed over while the sequencer was busy");

  // The end marker always closes the results of its frame.
  a_eom_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.out_kind == swfr_pkg::KIND_EOM)) |-> out_o.out_last)
    else $error("end-of-message result without last flag");

  // Payload bytes are always followed by the ack frame.
  a_payload_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.out_kind == swfr_pkg::KIND_PAYLOAD)) |-> !out_o.out_last)
    else $error("payload result marked as last");

endmodule

`default_nettype wire

/* tb/swfr_checker.sv */
// Scoreboard for the stop-and-wait frame receiver: follows byte, result and
// configuration requests, predicts each burst of results and compares them.
// Depends on swfr_pkg and swfr_if.
module swfr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  swfr_in_if          in_mon,
  swfr_out_if         out_mon,
  swfr_cfg_if         cfg_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output logic        seq_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import swfr_pkg::*;

  localparam logic [7:0] OWN_RESET   = 8'd66;
  localparam logic [7:0] PEER_RESET  = 8'd65;
  localparam logic [7:0] START_RESET = 8'd111;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  logic [7:0] own_addr;
  logic [7:0] peer_addr;
  logic [7:0] start_byte;
  logic       strip_pad;

  logic [7:0] rx_store [FRAME_LEN];
  logic [3:0] rx_count;
  logic       seq_bit;

  result_t    expected_results [$];

  // Takes one received byte and queues whatever results it releases.
  function automatic void predict_frame_results(input logic [7:0] b, input logic fin);
    logic       par;
    logic       accept;
    kind_e      kinds [9];
    logic [7:0] vals [9];
    int         n;
    result_t    r;
    if (rx_count < FRAME_LEN) rx_store[rx_count] = b;
    if (rx_count < COUNT_OVER) rx_count = rx_count + 4'd1;
    if (!fin) return;
    par = 1'b0;
    for (int i = 0; i < 6; i++) par ^= rx_store[i][0];
    accept = (rx_count == FRAME_LEN) && (rx_store[1] == own_addr)
          && (rx_store[3] == ASCII_ZERO + {7'b0, seq_bit})
          && (rx_store[6] == ASCII_ZERO + {7'b0, par});
    rx_count = 4'd0;
    if (!accept) return;
    seq_bit = ~seq_bit;
    n = 0;
    for (int i = 4; i < 6; i++) begin
      if (!(strip_pad && rx_store[i] == PAD_CHAR)) begin
        kinds[n] = KIND_PAYLOAD;
        vals[n]  = rx_store[i];
        n++;
      end
    end
    vals[n]     = start_byte;
    vals[n + 1] = peer_addr;
    vals[n + 2] = own_addr;
    vals[n + 3] = ASCII_ZERO + {7'b0, seq_bit};
    vals[n + 4] = ASCII_ZERO + {7'b0, ^{start_byte[0], peer_addr[0], own_addr[0],
                                        vals[n + 3][0]}};
    vals[n + 5] = ASCII_ZERO;
    for (int i = 0; i < 6; i++) kinds[n + i] = KIND_ACK;
    n += 6;
    if (rx_store[7] == ASCII_ZERO) begin
      seq_bit  = 1'b0;
      kinds[n] = KIND_EOM;
      vals[n]  = 8'h00;
      n++;
    end
    for (int i = 0; i < n; i++) begin
      r.kind = kinds[i];
      r.data = vals[i];
      r.last = (i == n - 1);
      expected_results.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      own_addr   = OWN_RESET;
      peer_addr  = PEER_RESET;
      start_byte = START_RESET;
      strip_pad  = 1'b1;
      for (int i = 0; i < FRAME_LEN; i++) rx_store[i] = 8'h00;
      rx_count   = 4'd0;
      seq_bit    = 1'b0;
      expected_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
      seq_o        = 1'b0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_OWN_ADDRESS:   own_addr   = cfg_mon.data;
          REG_PEER_ADDRESS:  peer_addr  = cfg_mon.data;
          REG_START_FLAG:    start_byte = cfg_mon.data;
          REG_STRIP_PADDING: strip_pad  = cfg_mon.data[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        predict_frame_results(in_mon.rx_byte, in_mon.frame_end);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: out_kind %0d, out_byte %02h, out_last %0b",
                 out_mon.out_kind, out_mon.out_byte, out_mon.out_last);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (out_mon.out_kind !== want.kind) begin
            $error("out_kind: expected %0d, got %0d", want.kind, out_mon.out_kind);
            fail_count_o++;
          end
          if (out_mon.out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_mon.out_byte);
            fail_count_o++;
          end
          if (out_mon.out_last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_mon.out_last);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_results.size();
      seq_o     = seq_bit;
    end
  end

endmodule

/* tb/testbench.sv */
// Top of the frame receiver testbench: clock, reset, byte and configuration
// requests, random output stalls, and the final verdict.
// Depends on swfr_pkg, swfr_if, swfr_checker and stop_wait_frame_receiver_top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import swfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned PHASE_BYTES   = 67;
  localparam logic [7:0]  ASCII_ONE     = ASCII_ZERO + 8'd1;
  localparam logic [7:0]  OWN_RESET     = 8'd66;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_ADDR,
    FRAME_BAD_SEQ,
    FRAME_BAD_PARITY,
    FRAME_SHORT,
    FRAME_LONG
  } frame_flaw_e;

  logic        clk;
  logic        rst_n;
  int unsigned fails;
  int unsigned pending;
  logic        exp_seq;
  int unsigned cycles;
  bit          calm;
  logic [7:0]  own_addr;
  logic [7:0]  tx_frame [$];

  swfr_in_if  in_if ();
  swfr_out_if out_if ();
  swfr_cfg_if cfg_if ();

  stop_wait_frame_receiver_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  swfr_checker CHK (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .cfg_mon      (cfg_if),
    .fail_count_o (fails),
    .pending_o    (pending),
    .seq_o        (exp_seq)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Mostly no gap, some short ones and now and then a long one.
  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Output stalls come in episodes whose length idle_gap() draws.
  initial begin
    int stall;
    stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else if ($urandom_range(0, 2) == 0) begin
        stall = idle_gap();
        out_if.ready <= (stall == 0);
        if (stall > 0) stall--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request.
  task automatic push_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.rx_byte   <= b;
    in_if.frame_end <= fin;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      cfg_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Lets every pending result drain, then waits on for a rejected frame that
  // may still sit in the input stage.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] own, input logic [7:0] peer,
                                input logic [7:0] start, input logic strip);
    drain();
    write_reg(REG_OWN_ADDRESS, own);
    write_reg(REG_PEER_ADDRESS, peer);
    write_reg(REG_START_FLAG, start);
    // Only bit 0 of the padding register matters; the rest is noise.
    write_reg(REG_STRIP_PADDING, {7'($urandom_range(0, 127)), strip});
    cfg_if.valid <= 1'b0;
    own_addr = own;
  endtask

  // Builds a well-formed frame for the current address and sequence bit.
  function automatic void build_frame(input logic [7:0] lead, input logic [7:0] mid,
                                      input logic [7:0] pay0, input logic [7:0] pay1,
                                      input logic [7:0] tail);
    logic par;
    tx_frame = {lead, own_addr, mid, ASCII_ZERO + {7'b0, exp_seq}, pay0, pay1};
    par = 1'b0;
    foreach (tx_frame[i]) par ^= tx_frame[i][0];
    tx_frame.push_back(ASCII_ZERO + {7'b0, par});
    tx_frame.push_back(tail);
  endfunction

  task automatic send_tx_frame();
    foreach (tx_frame[i]) push_byte(tx_frame[i], i == tx_frame.size() - 1);
  endtask

  initial begin
    int          sent;
    int          r;
    bit          paused;
    frame_flaw_e flaw;
    logic [7:0]  pay [2];
    logic [7:0]  tail;

    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.rx_byte   <= 8'h00;
    in_if.frame_end <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= REG_OWN_ADDRESS;
    cfg_if.data     <= 8'h00;
    cycles   = 0;
    calm     = 1'b0;
    own_addr = OWN_RESET;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames at reset settings: leading padding stripped, a lone
    // end-marked byte, an overlong frame, then a message end.
    build_frame(8'h00, 8'hFF, PAD_CHAR, 8'hFF, ASCII_ONE);
    send_tx_frame();
    tx_frame = {8'hFF};
    send_tx_frame();
    build_frame(8'h80, 8'h01, 8'h00, PAD_CHAR, ASCII_ZERO);
    tx_frame.push_back(8'h5A);
    send_tx_frame();
    build_frame(8'h7F, 8'hAA, 8'h00, 8'h55, ASCII_ZERO);
    send_tx_frame();

    for (int phase = 1; phase <= 5; phase++) begin
      case (phase)
        1: apply_settings(8'h00, 8'hFF, 8'h00, 1'b0);
        2: apply_settings(8'hFF, 8'h00, 8'hFF, 1'b1);
        3: apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'b0);
        4: apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'b1);
        default: apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      endcase
      calm   = (phase == 2);
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_BYTES) begin
        r = $urandom_range(0, 99);
        flaw = (r < 65) ? FRAME_GOOD : (r < 72) ? FRAME_BAD_ADDR :
               (r < 79) ? FRAME_BAD_SEQ : (r < 86) ? FRAME_BAD_PARITY :
               (r < 93) ? FRAME_SHORT : FRAME_LONG;
        foreach (pay[i])
          pay[i] = ($urandom_range(0, 3) == 0) ? PAD_CHAR : 8'($urandom_range(0, 255));
        r = $urandom_range(0, 9);
        tail = (r < 4) ? ASCII_ZERO : (r < 8) ? ASCII_ONE : 8'($urandom_range(0, 255));
        build_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    pay[0], pay[1], tail);
        case (flaw)
          FRAME_BAD_ADDR:   tx_frame[1] ^= 8'd1 << $urandom_range(0, 7);
          FRAME_BAD_SEQ:    tx_frame[3] ^= 8'd1 << $urandom_range(0, 7);
          FRAME_BAD_PARITY: tx_frame[6] ^= 8'd1 << $urandom_range(0, 7);
          FRAME_SHORT: begin
            r = $urandom_range(1, 7);
            while (tx_frame.size() > r) void'(tx_frame.pop_back());
          end
          FRAME_LONG:
            repeat ($urandom_range(1, 12)) tx_frame.push_back(8'($urandom_range(0, 255)));
          default: ;
        endcase
        send_tx_frame();
        sent += tx_frame.size();
        // Once, hold the sender until the receiver has caught up completely.
        if (phase == 3 && !paused && sent > PHASE_BYTES / 2) begin
          paused = 1'b1;
          in_if.valid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
      end
    end

    in_if.valid <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
